[hw/rtl/csalu_pkg.sv]
package csalu_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DivSteps = DataW;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVF  = 2'd1;
  localparam logic [1:0] STATUS_DIV0 = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic             neg;
    logic [DataW-1:0] mb;
    logic [DataW:0]   rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] res;
    logic [1:0]       status;
  } stage_t;

  typedef struct packed {
    logic [DataW-1:0] p0;
    logic [DataW-1:0] p1;
    logic [DataW-1:0] p2;
    logic [DataW-1:0] p3;
  } mul_pp_t;

  typedef struct packed {
    logic             hi_nz;
    logic [DataW-1:0] lo;
  } mul_sum_t;

endpackage

[hw/rtl/checked_signed_alu.sv]
// Overflow-checked signed 64-bit ALU: add, subtract, multiply, or truncating divide, with
// status ok, signed overflow (value 0) or divide by zero (value 0). Fully pipelined: one item
// can enter every cycle while the result side is not stalled. The depth is set by the
// restoring divider, which resolves one quotient bit per stage over 64 stages; add and
// subtract finish at entry, multiply uses four 32x32 partial products over two stages,
// and all operations travel the same chain so results leave in order. A stall on the
// result side freezes the whole pipeline; no item is lost or repeated.
module checked_signed_alu
  import csalu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic signed [DataW-1:0] in_lhs,
  input  logic signed [DataW-1:0] in_rhs,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] out_value,
  output logic [1:0]              out_status
);

  localparam int unsigned NStages = DivSteps + 1;

  logic                    en;
  stage_t                  st_r [NStages];
  stage_t                  st_nxt [NStages];
  logic [NStages-1:0]      vld_r;
  mul_pp_t                 m1_r, m1_nxt;
  mul_sum_t                m2_r, m2_nxt;
  logic                    out_valid_r;
  logic [DataW-1:0]        out_value_r, out_value_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // entry: magnitudes, add/sub result and divide special cases
  always_comb begin
    logic [DataW-1:0] a, b, r;
    logic             na, nb, nr;
    a  = in_lhs;
    b  = in_rhs;
    na = a[DataW-1];
    nb = b[DataW-1];
    st_nxt[0]        = '0;
    st_nxt[0].func   = in_func;
    st_nxt[0].neg    = na ^ nb;
    st_nxt[0].mb     = nb ? (~b + 1'b1) : b;
    st_nxt[0].quo    = na ? (~a + 1'b1) : a;
    st_nxt[0].status = STATUS_OK;
    r = (in_func == FUNC_SUB) ? (a - b) : (a + b);
    nr = r[DataW-1];
    st_nxt[0].res = r;
    case (in_func)
      FUNC_ADD: if (na == nb && nr != na) st_nxt[0].status = STATUS_OVF;
      FUNC_SUB: if (na != nb && nr != na) st_nxt[0].status = STATUS_OVF;
      FUNC_MUL: st_nxt[0].status = STATUS_OK;
      FUNC_DIV: begin
        if (b == '0) st_nxt[0].status = STATUS_DIV0;
        else if (a == {1'b1, {(DataW-1){1'b0}}} && b == '1) st_nxt[0].status = STATUS_OVF;
      end
      default: st_nxt[0].status = STATUS_OK;
    endcase
  end

  // multiply partial products and their sum, aligned with stages 1 and 2
  always_comb begin
    logic [DataW/2-1:0] alo, ahi, blo, bhi;
    alo = st_r[0].quo[DataW/2-1:0];
    ahi = st_r[0].quo[DataW-1:DataW/2];
    blo = st_r[0].mb[DataW/2-1:0];
    bhi = st_r[0].mb[DataW-1:DataW/2];
    m1_nxt.p0 = alo * blo;
    m1_nxt.p1 = ahi * blo;
    m1_nxt.p2 = alo * bhi;
    m1_nxt.p3 = ahi * bhi;
  end

  always_comb begin
    logic [DataW/2+1:0] mid;
    logic [DataW-1:0]   hi;
    mid = {2'b00, m1_r.p0[DataW-1:DataW/2]} + {2'b00, m1_r.p1[DataW/2-1:0]}
        + {2'b00, m1_r.p2[DataW/2-1:0]};
    hi  = m1_r.p3 + {{(DataW/2){1'b0}}, m1_r.p1[DataW-1:DataW/2]}
        + {{(DataW/2){1'b0}}, m1_r.p2[DataW-1:DataW/2]}
        + {{(DataW-2){1'b0}}, mid[DataW/2+1:DataW/2]};
    m2_nxt.hi_nz = (hi != '0);
    m2_nxt.lo    = {mid[DataW/2-1:0], m1_r.p0[DataW/2-1:0]};
  end

  // restoring divide, one quotient bit per stage
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    always_comb begin
      logic [DataW:0]   sh, diff;
      logic             bit_q;
      logic [DataW-1:0] limit;
      sh    = {st_r[i].rem[DataW-1:0], st_r[i].quo[DataW-1]};
      diff  = sh - {1'b0, st_r[i].mb};
      bit_q = !diff[DataW];
      limit = st_r[i].neg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      st_nxt[i+1]     = st_r[i];
      st_nxt[i+1].rem = bit_q ? diff : sh;
      st_nxt[i+1].quo = {st_r[i].quo[DataW-2:0], bit_q};
      if (i == 2 && st_r[i].func == FUNC_MUL) begin
        if (m2_r.hi_nz || m2_r.lo > limit) begin
          st_nxt[i+1].status = STATUS_OVF;
          st_nxt[i+1].res    = '0;
        end else begin
          st_nxt[i+1].status = STATUS_OK;
          st_nxt[i+1].res    = st_r[i].neg ? (~m2_r.lo + 1'b1) : m2_r.lo;
        end
      end
    end
  end

  always_comb begin
    stage_t s;
    s = st_r[NStages-1];
    out_status_nxt = s.status;
    if (s.status != STATUS_OK) out_value_nxt = '0;
    else if (s.func == FUNC_DIV) out_value_nxt = s.neg ? (~s.quo + 1'b1) : s.quo;
    else out_value_nxt = s.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NStages-2:0], in_valid};
      out_valid_r <= vld_r[NStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NStages; k++) st_r[k] <= st_nxt[k];
      m1_r         <= m1_nxt;
      m2_r         <= m2_nxt;
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_no_status3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_OVF
                   || out_status == STATUS_DIV0))
    else $error("status code 3 produced");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> (out_value == '0))
    else $error("nonzero value on error");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(vld_r) && $stable(out_valid_r)))
    else $error("pipeline moved during stall");

endmodule
